@@ rtl/core/asc_pkg.sv @@
package asc_pkg;

    // Class codes of the sense classifier
    typedef enum logic [2:0] {
        CLS_OK           = 3'd0,
        CLS_DISCONNECTED = 3'd1,
        CLS_SHORT        = 3'd2,
        CLS_OPEN         = 3'd3,
        CLS_FAULT        = 3'd4
    } t_class;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SHORT_ENTER = 3'd0,
        REG_SHORT_EXIT  = 3'd1,
        REG_OPEN_EXIT   = 3'd2,
        REG_OPEN_ENTER  = 3'd3,
        REG_CONFIRM     = 3'd4
    } t_reg_index;

    localparam int unsigned MV_W    = 16;
    localparam int unsigned RUN_W   = 8;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned CLASS_W = 3;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    localparam logic [MV_W-1:0]  RST_SHORT_ENTER = 16'd200;
    localparam logic [MV_W-1:0]  RST_SHORT_EXIT  = 16'd300;
    localparam logic [MV_W-1:0]  RST_OPEN_EXIT   = 16'd2700;
    localparam logic [MV_W-1:0]  RST_OPEN_ENTER  = 16'd2800;
    localparam logic [RUN_W-1:0] RST_CONFIRM     = 8'd3;

    // Window thresholds handed to the classifier
    typedef struct packed {
        logic [MV_W-1:0] short_enter;
        logic [MV_W-1:0] short_exit;
        logic [MV_W-1:0] open_exit;
        logic [MV_W-1:0] open_enter;
    } t_thresh;

endpackage

@@ rtl/core/accessory_sense_classifier_debounce_unit.sv @@
// Accessory sense classifier: each input beat (connector present, measurement
// valid, sense voltage in mV) yields one result beat with the debounced class,
// a changed flag, the two mute lines and wrapping fault and transition totals.
// The block sustains one beat per cycle while the output is not stalled; a beat
// passes through the input register and then the result register. The feedback
// through the classifier and the debounce state registers sets that rate. The
// user must write thresholds and the confirm count through the configuration
// port (always ready) only while the block is idle; it is not enforced.
module accessory_sense_classifier_debounce_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_connector_present,
    input  logic        i_measurement_valid,
    input  logic [15:0] i_sense_millivolts,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_confirmed_class,
    output logic        o_class_changed,
    output logic        o_mute_tx,
    output logic        o_mute_rx,
    output logic [31:0] o_fault_total,
    output logic [31:0] o_change_total,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import asc_pkg::*;

    // configuration
    t_thresh          r_thresh;
    logic [RUN_W-1:0] r_confirm;

    // input register
    logic             r_in_valid;
    logic             r_present;
    logic             r_meas_valid;
    logic [MV_W-1:0]  r_mv;

    // debounce state
    t_class             r_conf;
    t_class             r_pend;
    logic [RUN_W-1:0]   r_run;
    logic [COUNT_W-1:0] r_fault;
    logic [COUNT_W-1:0] r_change;

    // result register
    logic               r_out_valid;
    logic [CLASS_W-1:0] r_out_class;
    logic               r_out_changed;
    logic               r_out_mute_tx;
    logic               r_out_mute_rx;
    logic [COUNT_W-1:0] r_out_fault;
    logic [COUNT_W-1:0] r_out_change;

    t_class             raw;
    t_class             n_conf;
    t_class             n_pend;
    logic [RUN_W-1:0]   n_run;
    logic [COUNT_W-1:0] n_fault;
    logic [COUNT_W-1:0] n_change;
    logic               changed;
    logic               out_free;
    logic               advance;
    logic               in_accept;

    // Handshake: the input register takes a beat whenever it is empty or can move on
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.short_enter <= RST_SHORT_ENTER;
            r_thresh.short_exit  <= RST_SHORT_EXIT;
            r_thresh.open_exit   <= RST_OPEN_EXIT;
            r_thresh.open_enter  <= RST_OPEN_ENTER;
            r_confirm            <= RST_CONFIRM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SHORT_ENTER: r_thresh.short_enter <= i_cfg_data;
                REG_SHORT_EXIT:  r_thresh.short_exit  <= i_cfg_data;
                REG_OPEN_EXIT:   r_thresh.open_exit   <= i_cfg_data;
                REG_OPEN_ENTER:  r_thresh.open_enter  <= i_cfg_data;
                REG_CONFIRM:     r_confirm            <= i_cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the accepted beat in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_present    <= i_connector_present;
            r_meas_valid <= i_measurement_valid;
            r_mv         <= i_sense_millivolts;
        end
    end

    asc_classify u_classify (
        .i_present   (r_present),
        .i_valid     (r_meas_valid),
        .i_mv        (r_mv),
        .i_thresh    (r_thresh),
        .i_confirmed (r_conf),
        .o_raw       (raw)
    );

    // Debounce: restart the run on a new class, otherwise extend it, saturating at the top
    always_comb begin
        if (raw != r_pend) begin
            n_pend = raw;
            n_run  = {{(RUN_W-1){1'b0}}, 1'b1};
        end else begin
            n_pend = r_pend;
            n_run  = (r_run < RUN_MAX) ? r_run + 1'b1 : r_run;
        end
        changed  = (n_pend != r_conf) && (n_run >= r_confirm);
        n_conf   = changed ? n_pend : r_conf;
        n_change = changed ? r_change + 1'b1 : r_change;
        n_fault  = (raw != CLS_OK) ? r_fault + 1'b1 : r_fault;
    end

    // Advance debounce state once per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf   <= CLS_FAULT;
            r_pend   <= CLS_FAULT;
            r_run    <= '0;
            r_fault  <= '0;
            r_change <= '0;
        end else if (advance) begin
            r_conf   <= n_conf;
            r_pend   <= n_pend;
            r_run    <= n_run;
            r_fault  <= n_fault;
            r_change <= n_change;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_class   <= n_conf;
            r_out_changed <= changed;
            r_out_mute_tx <= (raw != CLS_OK) || (n_conf != CLS_OK);
            r_out_mute_rx <= !r_present || !r_meas_valid;
            r_out_fault   <= n_fault;
            r_out_change  <= n_change;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_confirmed_class = r_out_class;
    assign o_class_changed   = r_out_changed;
    assign o_mute_tx         = r_out_mute_tx;
    assign o_mute_rx         = r_out_mute_rx;
    assign o_fault_total     = r_out_fault;
    assign o_change_total    = r_out_change;

endmodule

@@ rtl/core/asc_classify.sv @@
module asc_classify (
    input  logic               i_present,
    input  logic               i_valid,
    input  logic [15:0]        i_mv,
    input  asc_pkg::t_thresh   i_thresh,
    input  asc_pkg::t_class    i_confirmed,
    output asc_pkg::t_class    o_raw
);
    import asc_pkg::*;

    // Classify one sample; hold windows apply against the confirmed class
    always_comb begin
        priority if (!i_valid) begin
            o_raw = CLS_FAULT;
        end else if (!i_present) begin
            o_raw = CLS_DISCONNECTED;
        end else if (i_confirmed == CLS_SHORT && i_mv < i_thresh.short_exit) begin
            o_raw = CLS_SHORT;
        end else if (i_confirmed == CLS_OPEN && i_mv > i_thresh.open_exit) begin
            o_raw = CLS_OPEN;
        end else if (i_mv <= i_thresh.short_enter) begin
            o_raw = CLS_SHORT;
        end else if (i_mv >= i_thresh.open_enter) begin
            o_raw = CLS_OPEN;
        end else begin
            o_raw = CLS_OK;
        end
    end

endmodule

@@ rtl/core/asc_checker.sv @@
module asc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_confirmed_class,
    input logic        o_mute_tx,
    input logic        o_mute_rx,
    input logic [31:0] o_change_total
);
    import asc_pkg::*;

    // No result beat right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A non-ok confirmed class always mutes transmit
    a_conf_mutes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_confirmed_class != CLS_OK) |-> o_mute_tx)
        else $error("confirmed class not ok but transmit not muted");

    // Absent connector or bad measurement gives a non-ok raw class
    a_rx_implies_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mute_rx |-> o_mute_tx)
        else $error("receive muted without transmit mute");

    // Stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_change_total)
            && $stable(o_confirmed_class))
        else $error("stalled result changed");

endmodule

bind accessory_sense_classifier_debounce_unit asc_checker u_asc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_confirmed_class (o_confirmed_class),
    .o_mute_tx         (o_mute_tx),
    .o_mute_rx         (o_mute_rx),
    .o_change_total    (o_change_total)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import asc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        t_class      cls;
        logic        changed;
        logic        mute_tx;
        logic        mute_rx;
        logic [31:0] faults;
        logic [31:0] changes;
    } t_sense_result;

    // Voltage zones used to build runs of alike samples
    typedef enum int {
        Z_FAULT, Z_DISC, Z_SHORT, Z_SHORT_HOLD, Z_OK, Z_OPEN_HOLD, Z_OPEN, Z_EDGE
    } t_zone;

    // Debounced classifier model plus the queue of results still owed by the block
    class sense_scoreboard;
        logic [15:0]   short_enter;
        logic [15:0]   short_exit;
        logic [15:0]   open_exit;
        logic [15:0]   open_enter;
        logic [7:0]    confirm_need;
        t_class        confirmed;
        t_class        candidate;
        logic [7:0]    run_len;
        logic [31:0]   fault_count;
        logic [31:0]   change_count;
        t_sense_result owed[$];
        int            errors;
        int            accepted;
        int            checked;

        function new();
            short_enter  = RST_SHORT_ENTER;
            short_exit   = RST_SHORT_EXIT;
            open_exit    = RST_OPEN_EXIT;
            open_enter   = RST_OPEN_ENTER;
            confirm_need = RST_CONFIRM;
            confirmed    = CLS_FAULT;
            candidate    = CLS_FAULT;
            run_len      = '0;
            fault_count  = '0;
            change_count = '0;
            errors       = 0;
            accepted     = 0;
            checked      = 0;
        endfunction

        function void set_reg(t_reg_index idx, logic [15:0] data);
            case (idx)
                REG_SHORT_ENTER: short_enter  = data;
                REG_SHORT_EXIT:  short_exit   = data;
                REG_OPEN_EXIT:   open_exit    = data;
                REG_OPEN_ENTER:  open_enter   = data;
                REG_CONFIRM:     confirm_need = data[7:0];
                default: ;
            endcase
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10) $display("mismatch: %s", what);
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        // Raw class: hold windows against the confirmed class come before the enter windows
        function t_class classify(logic present, logic valid, logic [15:0] mv);
            if (!valid) return CLS_FAULT;
            if (!present) return CLS_DISCONNECTED;
            if (confirmed == CLS_SHORT && mv < short_exit) return CLS_SHORT;
            if (confirmed == CLS_OPEN && mv > open_exit) return CLS_OPEN;
            if (mv <= short_enter) return CLS_SHORT;
            if (mv >= open_enter) return CLS_OPEN;
            return CLS_OK;
        endfunction

        function void note_sample(logic present, logic valid, logic [15:0] mv);
            t_class        raw;
            t_sense_result res;
            raw = classify(present, valid, mv);
            res.changed = 1'b0;
            if (raw != CLS_OK) fault_count++;
            // advance the candidate run, saturating at the top
            if (raw != candidate) begin
                candidate = raw;
                run_len   = 8'd1;
            end else if (run_len != RUN_MAX) begin
                run_len++;
            end
            if (candidate != confirmed && run_len >= confirm_need) begin
                confirmed = candidate;
                change_count++;
                res.changed = 1'b1;
            end
            res.cls     = confirmed;
            res.mute_tx = (raw != CLS_OK) || (confirmed != CLS_OK);
            res.mute_rx = !present || !valid;
            res.faults  = fault_count;
            res.changes = change_count;
            owed.push_back(res);
            accepted++;
        endfunction

        function void check_result(logic [2:0] cls, logic changed, logic mute_tx,
                                   logic mute_rx, logic [31:0] faults, logic [31:0] changes);
            t_sense_result want;
            if (owed.size() == 0) begin
                flag($sformatf("result beat with nothing expected (class %0d)", cls));
                return;
            end
            want = owed.pop_front();
            checked++;
            if (want.cls !== cls || want.changed !== changed || want.mute_tx !== mute_tx ||
                want.mute_rx !== mute_rx || want.faults !== faults || want.changes !== changes)
                flag($sformatf({"beat %0d: expected cls %0d chg %b mtx %b mrx %b flt %0d chn %0d,",
                                " got cls %0d chg %b mtx %b mrx %b flt %0d chn %0d"},
                               checked, want.cls, want.changed, want.mute_tx, want.mute_rx,
                               want.faults, want.changes, cls, changed, mute_tx, mute_rx,
                               faults, changes));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_connector_present = 1'b0;
    logic        i_measurement_valid = 1'b0;
    logic [15:0] i_sense_millivolts = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_confirmed_class;
    logic        o_class_changed;
    logic        o_mute_tx;
    logic        o_mute_rx;
    logic [31:0] o_fault_total;
    logic [31:0] o_change_total;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    sense_scoreboard sb;
    int idle_pct = 0;
    int stall_pct = 0;
    int settings_used = 1;
    int cycle_count = 0;

    accessory_sense_classifier_debounce_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_connector_present (i_connector_present),
        .i_measurement_valid (i_measurement_valid),
        .i_sense_millivolts  (i_sense_millivolts),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_confirmed_class   (o_confirmed_class),
        .o_class_changed     (o_class_changed),
        .o_mute_tx           (o_mute_tx),
        .o_mute_rx           (o_mute_rx),
        .o_fault_total       (o_fault_total),
        .o_change_total      (o_change_total),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[accessory_sense_classifier_debounce_unit] ERROR");
            $finish;
        end
    end

    // Random receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check a result beat between edges; it is taken at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_confirmed_class, o_class_changed, o_mute_tx, o_mute_rx,
                            o_fault_total, o_change_total);
    end

    task automatic send_sample(input logic present, input logic valid, input logic [15:0] mv);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_connector_present <= present;
        i_measurement_valid <= valid;
        i_sense_millivolts  <= mv;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        sb.note_sample(present, valid, mv);
    endtask

    // Hold off the sender until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int se, input int sx, input int ox, input int oe,
                                 input int cc);
        logic [15:0] vals [5];
        logic        taken;
        vals[0] = 16'(se);
        vals[1] = 16'(sx);
        vals[2] = 16'(ox);
        vals[3] = 16'(oe);
        vals[4] = 16'(cc & 8'hFF);
        for (int k = 0; k < 5; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_reg_index'(k);
            i_cfg_data  <= vals[k];
            do begin
                @(negedge i_clk);
                taken = o_cfg_ready;
                @(posedge i_clk);
            end while (!taken);
            sb.set_reg(t_reg_index'(k), vals[k]);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] span(input int lo, input int hi);
        if (lo < 0) lo = 0;
        if (hi > 65535) hi = 65535;
        if (lo > hi) return 16'($urandom_range(65535));
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [15:0] mv_in_zone(input t_zone zone);
        int se;
        int sx;
        int ox;
        int oe;
        int pick;
        se = int'(sb.short_enter);
        sx = int'(sb.short_exit);
        ox = int'(sb.open_exit);
        oe = int'(sb.open_enter);
        case (zone)
            Z_SHORT:      return span(0, se);
            Z_SHORT_HOLD: return span(se + 1, sx - 1);
            Z_OK:         return span(se + 1, oe - 1);
            Z_OPEN_HOLD:  return span(ox + 1, oe - 1);
            Z_OPEN:       return span(oe, 65535);
            Z_EDGE: begin
                // land on or next to one of the four thresholds
                case ($urandom_range(3))
                    0: pick = se;
                    1: pick = sx;
                    2: pick = ox;
                    default: pick = oe;
                endcase
                pick = pick + int'($urandom_range(2)) - 1;
                return span(pick, pick);
            end
            default:      return 16'($urandom_range(65535));
        endcase
    endfunction

    // Mostly runs of alike samples, from one to two or three past the confirm count, with some noise between
    task automatic random_samples(input int count);
        int    sent;
        int    run;
        bit    paused;
        t_zone zone;
        sent   = 0;
        paused = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                send_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                            16'($urandom_range(65535)));
                sent++;
            end else begin
                zone = t_zone'($urandom_range(Z_EDGE));
                run  = $urandom_range(int'(sb.confirm_need) + (sb.confirm_need > 8 ? 3 : 2), 1);
                for (int k = 0; k < run && sent < count; k++) begin
                    case (zone)
                        Z_FAULT: send_sample(1'($urandom_range(1)), 1'b0,
                                             16'($urandom_range(65535)));
                        Z_DISC:  send_sample(1'b0, 1'b1, 16'($urandom_range(65535)));
                        default: send_sample(1'b1, 1'b1, mv_in_zone(zone));
                    endcase
                    sent++;
                end
            end
            if (!paused && sent >= count / 2) begin
                drain_results();
                paused = 1;
            end
        end
    endtask

    task automatic run_phase(input int se, input int sx, input int ox, input int oe,
                             input int cc, input int idle, input int stall, input int count);
        drain_results();
        apply_setting(se, sx, ox, oe, cc);
        idle_pct  = idle;
        stall_pct = stall;
        random_samples(count);
    endtask

    // Reset thresholds: fault, disconnect, both windows with hysteresis, broken runs
    task automatic directed_samples();
        send_sample(1'b0, 1'b0, 16'd0);
        send_sample(1'b1, 1'b0, 16'd65535);
        send_sample(1'b0, 1'b1, 16'd1234);
        send_sample(1'b0, 1'b1, 16'd0);
        send_sample(1'b0, 1'b1, 16'd65535);
        send_sample(1'b1, 1'b1, 16'd0);
        send_sample(1'b1, 1'b1, 16'd200);
        send_sample(1'b1, 1'b1, 16'd100);
        send_sample(1'b1, 1'b1, 16'd299);
        send_sample(1'b1, 1'b1, 16'd300);
        send_sample(1'b1, 1'b1, 16'd201);
        send_sample(1'b1, 1'b1, 16'd2799);
        send_sample(1'b1, 1'b1, 16'd2800);
        send_sample(1'b1, 1'b1, 16'd65535);
        send_sample(1'b1, 1'b1, 16'd2801);
        send_sample(1'b1, 1'b1, 16'd2701);
        send_sample(1'b1, 1'b1, 16'd2700);
        send_sample(1'b1, 1'b1, 16'd250);
        send_sample(1'b1, 1'b1, 16'd1500);
        send_sample(1'b1, 1'b1, 16'd200);
        send_sample(1'b1, 1'b0, 16'd200);
        send_sample(1'b1, 1'b1, 16'd200);
        send_sample(1'b1, 1'b1, 16'd0);
        send_sample(1'b1, 1'b1, 16'd150);
    endtask

    initial begin
        int se;
        int sx;
        int ox;
        int oe;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_samples();
        random_samples(250);

        run_phase(100, 1000, 50000, 60000, 1, 66, 0, 300);
        run_phase(0, 0, 65535, 65535, 255, 0, 66, 450);
        run_phase(65535, 65535, 0, 0, 2, 38, 38, 200);
        run_phase(3000, 2000, 1000, 500, 4, 38, 38, 200);
        se = $urandom_range(20000);
        sx = se + $urandom_range(5000);
        ox = sx + $urandom_range(20000);
        oe = ox + $urandom_range(10000);
        run_phase(se, sx, ox, oe, $urandom_range(6, 1), 38, 38, 200);
        run_phase(200, 300, 2700, 2800, 3, 0, 0, 100);

        drain_results();
        repeat (6) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.flag($sformatf("%0d expected results never arrived", sb.outstanding()));

        $display("covered %0d samples under %0d threshold settings, %0d results checked",
                 sb.accepted, settings_used, sb.checked);
        $display("confirmed class changed %0d times, %0d samples classed non-ok, %0d errors",
                 sb.change_count, sb.fault_count, sb.errors);
        if (sb.errors == 0) begin
            $display("[accessory_sense_classifier_debounce_unit] OK");
        end else begin
            $display("[accessory_sense_classifier_debounce_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ accessory_sense_classifier_debounce_unit.f @@
rtl/core/asc_pkg.sv
rtl/core/asc_classify.sv
rtl/core/accessory_sense_classifier_debounce_unit.sv
rtl/core/asc_checker.sv
bench/tb.sv
